/* rtl/ascii_decimal_integer_parser_assert.svh */
// Assertion macros used by the checker file of the decimal parser.
// No dependencies; included by file name where assertions are written.
`ifndef ASCII_DECIMAL_INTEGER_PARSER_ASSERT_SVH
`define ASCII_DECIMAL_INTEGER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADIP_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("adip: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ADIP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("adip: next-cycle check failed");

`endif

/* rtl/adip_pkg.sv */
// Shared types, widths and character codes of the decimal parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package adip_pkg;

	localparam int VALUE_BITS    = 32;
	localparam int MAG_BITS      = VALUE_BITS - 1;
	localparam int PROD_BITS     = MAG_BITS + 4;
	localparam int TIMER_BITS    = 16;
	localparam int SKIP_BITS     = 8;
	localparam int TIMEOUT_BITS  = 16;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CMP_BITS      = (TIMER_BITS > TIMEOUT_BITS) ? TIMER_BITS : TIMEOUT_BITS;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [PROD_BITS-1:0]  RADIX     = PROD_BITS'(10);
	localparam logic [MAG_BITS-1:0]   MAG_MAX   = {MAG_BITS{1'b1}};
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	localparam logic [SKIP_BITS-1:0]    SKIP_RESET    = SKIP_BITS'(1);
	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(1000);

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SKIP_CHAR = 1'b0,
		REG_TIMEOUT   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [SKIP_BITS-1:0]    skip_char;
		logic [TIMEOUT_BITS-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic                         timed_out;
		logic                         overflow;
	} result_t;

endpackage

/* rtl/adip_cfg.sv */
// Configuration registers of the decimal parser: skip character and timeout.
// Depends on adip_pkg.
`timescale 1ns / 1ps

module adip_cfg import adip_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_t                     cfg
);

	logic [SKIP_BITS-1:0]    skip_char_q;
	logic [TIMEOUT_BITS-1:0] timeout_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_char_q     <= SKIP_RESET;
			timeout_ticks_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_SKIP_CHAR: skip_char_q     <= cfg_data[SKIP_BITS-1:0];
				REG_TIMEOUT:   timeout_ticks_q <= cfg_data[TIMEOUT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.skip_char     = skip_char_q;
	assign cfg.timeout_ticks = timeout_ticks_q;

endmodule

/* rtl/adip_parse.sv */
// Parse state registers and the combinational next-state / result logic.
// Depends on adip_pkg.
`timescale 1ns / 1ps

module adip_parse import adip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       take,
	input  logic       cmd,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	logic                  in_number_q, in_number_d;
	logic                  negative_q, negative_d;
	logic [MAG_BITS-1:0]   magnitude_q, magnitude_d;
	logic                  saturated_q, saturated_d;
	logic [TIMER_BITS-1:0] idle_ticks_q, idle_ticks_d;

	logic                  is_digit, is_minus, is_skip;
	logic [PROD_BITS-1:0]  prod;
	logic                  sat_hit;
	logic [TIMER_BITS-1:0] idle_inc;
	logic                  timeout_hit;
	logic [VALUE_BITS-1:0] mag_ext;

	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_minus = (rx_byte == CH_MINUS);
	assign is_skip  = (rx_byte == cfg.skip_char);

	// digit value is the low nibble for '0'..'9'
	assign prod    = PROD_BITS'(magnitude_q) * RADIX + PROD_BITS'(rx_byte[3:0]);
	assign sat_hit = saturated_q || (prod > PROD_BITS'(MAG_MAX));

	assign idle_inc    = (idle_ticks_q != TIMER_MAX) ? idle_ticks_q + 1'b1 : idle_ticks_q;
	assign timeout_hit = CMP_BITS'(idle_inc) >= CMP_BITS'(cfg.timeout_ticks);

	assign mag_ext = VALUE_BITS'(magnitude_q);

	always_comb begin
		in_number_d   = in_number_q;
		negative_d    = negative_q;
		magnitude_d   = magnitude_q;
		saturated_d   = saturated_q;
		idle_ticks_d  = idle_ticks_q;
		res_valid     = 1'b0;
		res.value     = negative_q ? -$signed(mag_ext) : $signed(mag_ext);
		res.timed_out = 1'b0;
		res.overflow  = saturated_q;
		if (take) begin
			case (cmd_t'(cmd))
				CMD_TICK: begin
					if (timeout_hit) begin
						idle_ticks_d  = '0;
						res_valid     = 1'b1;
						res.timed_out = 1'b1;
						in_number_d   = 1'b0;
						negative_d    = 1'b0;
						magnitude_d   = '0;
						saturated_d   = 1'b0;
					end else begin
						idle_ticks_d = idle_inc;
					end
				end
				CMD_BYTE: begin
					idle_ticks_d = '0;
					if (in_number_q || is_minus || is_digit) begin
						in_number_d = 1'b1;
						if (is_skip) begin
							// separator: no effect
						end else if (is_minus) begin
							negative_d = 1'b1;
						end else if (is_digit) begin
							if (sat_hit) begin
								magnitude_d = MAG_MAX;
								saturated_d = 1'b1;
							end else begin
								magnitude_d = prod[MAG_BITS-1:0];
							end
						end else begin
							// ending byte: emit and drop it
							res_valid   = 1'b1;
							in_number_d = 1'b0;
							negative_d  = 1'b0;
							magnitude_d = '0;
							saturated_d = 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_number_q  <= 1'b0;
			negative_q   <= 1'b0;
			magnitude_q  <= '0;
			saturated_q  <= 1'b0;
			idle_ticks_q <= '0;
		end else begin
			in_number_q  <= in_number_d;
			negative_q   <= negative_d;
			magnitude_q  <= magnitude_d;
			saturated_q  <= saturated_d;
			idle_ticks_q <= idle_ticks_d;
		end
	end

endmodule

/* rtl/adip_obuf.sv */
// Result register with one skid entry between the parser and the output channel.
// Depends on adip_pkg.
`timescale 1ns / 1ps

module adip_obuf import adip_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	input  logic    out_stall,
	output logic    full,
	output logic    out_valid,
	output result_t dout
);

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    pop;

	assign pop = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= din;
			end else begin
				out_q <= din;
			end
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign dout      = out_q;

endmodule

/* rtl/ascii_decimal_integer_parser.sv */
// Decimal integer parser over a stream of received bytes and millisecond ticks.
// Input channel: in_valid / in_stall with cmd (0 = byte, 1 = tick) and rx_byte.
// Output channel: out_valid / out_stall with value, timed_out and overflow.
// Config port: cfg_we writes cfg_data into cfg_idx (0 skip char, 1 timeout
// ticks); the user must write only while idle; the block does not enforce it.
// An input transfer is taken every cycle while in_stall is low; the parse step
// is one pass of compare, multiply-by-ten and add between the state registers
// and the result register, which (or the skid entry, while the receiver
// stalls) registers the result of the byte or tick that ends the number.
// Most input transfers create no result; ending bytes and timeouts create one.
// Reset (arst_n low) returns to seeking, clears the idle counter, empties the
// output stage and loads skip char 1 and timeout 1000.
// When the receiver stalls, the result register holds its result and a skid
// entry takes one more; in_stall rises only while the skid entry is full and
// drops in the cycle after the output transfer frees it.
// Depends on adip_pkg, adip_cfg, adip_parse and adip_obuf.
`timescale 1ns / 1ps

module ascii_decimal_integer_parser import adip_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_BITS-1:0]      cfg_idx,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic [7:0]                   rx_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [VALUE_BITS-1:0] value,
	output logic                         timed_out,
	output logic                         overflow
);

	cfg_t    cfg;
	logic    take;
	logic    res_valid;
	result_t res;
	result_t dout;
	logic    buf_full;

	// a transfer is taken whenever the skid entry is free
	assign in_stall = buf_full;
	assign take     = in_valid && !buf_full;

	adip_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	adip_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.take      (take),
		.cmd       (cmd),
		.rx_byte   (rx_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	adip_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.din       (res),
		.out_stall (out_stall),
		.full      (buf_full),
		.out_valid (out_valid),
		.dout      (dout)
	);

	assign value     = dout.value;
	assign timed_out = dout.timed_out;
	assign overflow  = dout.overflow;

endmodule

/* rtl/adip_checker.sv */
// Port-level checks of the decimal parser, bound to the top level.
// Depends on adip_pkg and ascii_decimal_integer_parser_assert.svh.
`timescale 1ns / 1ps
`include "ascii_decimal_integer_parser_assert.svh"

module adip_checker import adip_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [VALUE_BITS-1:0] value,
	input logic                         timed_out,
	input logic                         overflow
);

	localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, MAG_MAX};
	localparam logic signed [VALUE_BITS-1:0] VALUE_NEG = -VALUE_MAX;
	localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {MAG_BITS{1'b0}}};

	// input backpressure only while a result is held at the output
	`ADIP_ASSERT_SAME(a_stall_needs_result, clk, arst_n, in_stall, out_valid)

	// the input side stalls only after an output stall
	`ADIP_ASSERT_SAME(a_stall_from_output, clk, arst_n, $rose(in_stall),
		$past(out_valid && out_stall))

	// a saturated result carries the largest magnitude
	`ADIP_ASSERT_SAME(a_overflow_value, clk, arst_n, out_valid && overflow,
		(value == VALUE_MAX) || (value == VALUE_NEG))

	// a stalled result is held
	`ADIP_ASSERT_NEXT(a_hold_result, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(value) && $stable(timed_out) && $stable(overflow))

	// the most negative code never appears
	`ADIP_ASSERT_SAME(a_no_min_value, clk, arst_n, out_valid, value != VALUE_MIN)

endmodule

bind ascii_decimal_integer_parser adip_checker u_adip_checker (.*);
